// ===== rtl/http_reply_json_content_parser_macros.svh =====
// Assertion macros used by the HTTP reply parser top level.
`ifndef HTTP_REPLY_JSON_CONTENT_PARSER_MACROS_SVH
`define HTTP_REPLY_JSON_CONTENT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while reset is low.
`define HRJP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while reset is low.
`define HRJP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrjp_pkg.sv =====
// Types, constants and character tables of the HTTP reply parser.
package hrjp_pkg;

    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_0      = 8'h30;
    localparam logic [7:0]  CH_9      = 8'h39;

    localparam logic [3:0]  MIN_LEN     = 4'd12;
    localparam logic [3:0]  KEY_LAST    = 4'd8;
    localparam logic [2:0]  DIGITS_WANT = 3'd3;
    localparam logic [2:0]  DIGITS_SAT  = 3'd4;
    localparam logic [9:0]  STATUS_LO   = 10'd200;
    localparam logic [9:0]  STATUS_HI   = 10'd300;
    localparam logic [12:0] CAP_MAX     = 13'd4096;
    localparam logic [12:0] CAP_RESET   = 13'd512;

    typedef enum logic [1:0] {
        ST_SEEK_SPACE,
        ST_DIGITS,
        ST_DONE
    } t_status_phase;

    typedef enum logic [2:0] {
        JS_SEARCH,
        JS_SKIP,
        JS_STRING,
        JS_STOPPED,
        JS_FAILED
    } t_json_phase;

    typedef enum logic [1:0] {
        VERDICT_OK,
        VERDICT_HTTP_FAIL,
        VERDICT_PARSE_FAIL
    } t_verdict;

    // One result item plus a flag saying whether the byte produced one.
    typedef struct packed {
        logic       present;
        logic       has_char;
        logic [7:0] out_char;
        logic       final_res;
        t_verdict   verdict;
    } t_result;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h48;
            2'd1:    c = 8'h54;
            2'd2:    c = 8'h54;
            default: c = 8'h50;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] crlf_char(input logic [1:0] idx);
        return idx[0] ? CH_LF : CH_CR;
    endfunction

    // The quoted key "content", quotes included.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_QUOTE;
            4'd1:    c = 8'h63;
            4'd2:    c = 8'h6F;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h65;
            4'd6:    c = 8'h6E;
            4'd7:    c = 8'h74;
            4'd8:    c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/http_reply_json_content_parser.sv =====
// Top level of the HTTP reply parser: input register, parse core, result register.
//
// Usage: bytes of one HTTP response enter on the input channel (i_in_valid /
// o_in_ready) one per transfer, with i_last_byte set on the final byte. The
// block checks the status line and header framing, finds the first "content"
// key in the body and returns the characters of its quoted string value.
// Results leave on the output channel (o_out_valid / i_out_ready). A byte
// yields a result when it carries a content character, when it is the last
// byte of the response, or both; other bytes yield no transfer at all.
// On the result of the last byte o_final_res is high and o_verdict says
// ok, HTTP failure or parse failure; on failure the receiver drops the
// characters it has collected. The parse state clears itself after that byte.
// A byte accepted into the input register passes through the parse core into
// the result register, which presents it. Throughput is one byte per cycle
// while the receiver takes results, set by the single register-to-register
// step of the parse core. When the receiver stalls, the result register holds
// its transfer and the input register keeps one more byte; o_in_ready drops
// only while both are occupied. i_cfg_we writes the reply capacity; it is to
// be used only while no response is in flight, which the block does not enforce.
// Reset clears the valid flags and parse state and sets the capacity to 512.
module http_reply_json_content_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_char,
    output logic [7:0]  o_out_char,
    output logic        o_final_res,
    output logic [1:0]  o_verdict,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata
);
    import hrjp_pkg::*;

    `include "http_reply_json_content_parser_macros.svh"

    logic [12:0] r_capacity;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_res;
    logic        w_advance;

    // The registered byte moves through the core whenever the result slot is
    // free or is being emptied in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_in;
            r_in_last <= i_last_byte;
        end
    end

    hrjp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_capacity (r_capacity),
        .o_res      (w_res)
    );

    // A byte without a result simply leaves the result slot empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.present;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.present) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_has_char  = r_out.has_char;
    assign o_out_char  = r_out.out_char;
    assign o_final_res = r_out.final_res;
    assign o_verdict   = r_out.verdict;

    `HRJP_ASSERT_NOW(a_nonfinal_has_char, o_out_valid && !o_final_res, o_has_char,
        "result without final flag carries no character")
    `HRJP_ASSERT_NOW(a_char_zero, o_out_valid && !o_has_char, o_out_char == 8'h00,
        "character field not zero on a result without a character")
    `HRJP_ASSERT_NOW(a_verdict_idle, o_out_valid && !o_final_res, o_verdict == VERDICT_OK,
        "verdict set on a non-final result")
    `HRJP_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready,
        "input stalled while the result register is empty")

endmodule

// ===== rtl/hrjp_core.sv =====
// Per-response parse state and the combinational next-state logic for one byte.
module hrjp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic [12:0]      i_capacity,
    output hrjp_pkg::t_result o_res
);
    import hrjp_pkg::*;

    logic [3:0]    r_byte_count,   n_byte_count;
    logic          r_magic_ok,     n_magic_ok;
    t_status_phase r_status_phase, n_status_phase;
    logic [9:0]    r_status_value, n_status_value;
    logic [2:0]    r_digit_count,  n_digit_count;
    logic [1:0]    r_blank_match,  n_blank_match;
    logic          r_in_body,      n_in_body;
    logic          r_body_seen,    n_body_seen;
    logic [3:0]    r_key_match,    n_key_match;
    t_json_phase   r_json_phase,   n_json_phase;
    logic          r_escape,       n_escape;
    logic [11:0]   r_out_count,    n_out_count;

    logic [12:0] w_cap_eff;
    logic        w_full;
    logic        w_is_digit;
    logic        w_try_emit;
    logic        w_emit;
    logic        w_http_ok;

    // Capacity zero behaves as one, anything above the buffer limit as the limit.
    assign w_cap_eff  = (i_capacity == 13'd0) ? 13'd1 :
                        (i_capacity > CAP_MAX) ? CAP_MAX : i_capacity;
    assign w_full     = ({1'b0, r_out_count} + 13'd1) >= w_cap_eff;
    assign w_is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign w_try_emit = r_in_body && (r_json_phase == JS_STRING) &&
                        (r_escape || ((i_byte != CH_QUOTE) &&
                                      !((i_byte == CH_BSLASH) && !i_last)));
    assign w_emit     = w_try_emit && !w_full;

    assign w_http_ok  = (n_byte_count >= MIN_LEN) && n_magic_ok &&
                        (n_status_phase != ST_SEEK_SPACE) &&
                        (n_digit_count == DIGITS_WANT) &&
                        (n_status_value >= STATUS_LO) && (n_status_value < STATUS_HI);

    // Next state: the state as it stands after this byte, before the
    // end-of-response clear.
    always_comb begin
        n_byte_count   = r_byte_count;
        n_magic_ok     = r_magic_ok;
        n_status_phase = r_status_phase;
        n_status_value = r_status_value;
        n_digit_count  = r_digit_count;
        n_blank_match  = r_blank_match;
        n_in_body      = r_in_body;
        n_body_seen    = r_body_seen;
        n_key_match    = r_key_match;
        n_json_phase   = r_json_phase;
        n_escape       = r_escape;
        n_out_count    = r_out_count;

        if ((r_byte_count < 4'd4) && (i_byte != magic_char(r_byte_count[1:0]))) begin
            n_magic_ok = 1'b0;
        end
        if (r_byte_count < MIN_LEN) begin
            n_byte_count = r_byte_count + 4'd1;
        end

        unique case (r_status_phase)
            ST_SEEK_SPACE: begin
                if (i_byte == CH_SPACE) begin
                    n_status_phase = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (w_is_digit) begin
                    if (r_digit_count < DIGITS_WANT) begin
                        n_status_value = 10'(r_status_value * 10'd10
                                             + {2'b00, i_byte - CH_0});
                    end
                    if (r_digit_count < DIGITS_SAT) begin
                        n_digit_count = r_digit_count + 3'd1;
                    end
                end else begin
                    n_status_phase = ST_DONE;
                end
            end
            ST_DONE: begin
            end
            default: begin
                n_status_phase = ST_DONE;
            end
        endcase

        if (r_in_body) begin
            n_body_seen = 1'b1;
            unique case (r_json_phase)
                JS_SEARCH: begin
                    if (i_byte == key_char(r_key_match)) begin
                        if (r_key_match == KEY_LAST) begin
                            n_key_match  = 4'd0;
                            n_json_phase = JS_SKIP;
                        end else begin
                            n_key_match = r_key_match + 4'd1;
                        end
                    end else begin
                        n_key_match = (i_byte == CH_QUOTE) ? 4'd1 : 4'd0;
                    end
                end
                JS_SKIP: begin
                    if (i_byte == CH_QUOTE) begin
                        n_json_phase = JS_STRING;
                    end else if ((i_byte != CH_SPACE) && (i_byte != CH_TAB) &&
                                 (i_byte != CH_COLON)) begin
                        n_json_phase = JS_FAILED;
                    end
                end
                JS_STRING: begin
                    if (r_escape) begin
                        n_escape = 1'b0;
                    end else if (i_byte == CH_QUOTE) begin
                        n_json_phase = JS_STOPPED;
                    end else if ((i_byte == CH_BSLASH) && !i_last) begin
                        n_escape = 1'b1;
                    end
                    if (w_try_emit) begin
                        if (w_full) begin
                            n_json_phase = JS_STOPPED;
                        end else begin
                            n_out_count = r_out_count + 12'd1;
                        end
                    end
                end
                JS_STOPPED, JS_FAILED: begin
                end
                default: begin
                    n_json_phase = JS_FAILED;
                end
            endcase
        end else begin
            if (i_byte == crlf_char(r_blank_match)) begin
                if (r_blank_match == 2'd3) begin
                    n_in_body     = 1'b1;
                    n_blank_match = 2'd0;
                end else begin
                    n_blank_match = r_blank_match + 2'd1;
                end
            end else begin
                n_blank_match = (i_byte == CH_CR) ? 2'd1 : 2'd0;
            end
        end
    end

    // Result for this byte.
    always_comb begin
        o_res.present   = w_emit || i_last;
        o_res.has_char  = w_emit;
        o_res.out_char  = w_emit ? i_byte : 8'h00;
        o_res.final_res = i_last;
        if (!i_last) begin
            o_res.verdict = VERDICT_OK;
        end else if (!w_http_ok) begin
            o_res.verdict = VERDICT_HTTP_FAIL;
        end else if (!n_body_seen) begin
            o_res.verdict = VERDICT_PARSE_FAIL;
        end else if (((n_json_phase == JS_STRING) || (n_json_phase == JS_STOPPED)) &&
                     (n_out_count != 12'd0)) begin
            o_res.verdict = VERDICT_OK;
        end else begin
            o_res.verdict = VERDICT_PARSE_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_byte_count   <= 4'd0;
            r_magic_ok     <= 1'b1;
            r_status_phase <= ST_SEEK_SPACE;
            r_status_value <= 10'd0;
            r_digit_count  <= 3'd0;
            r_blank_match  <= 2'd0;
            r_in_body      <= 1'b0;
            r_body_seen    <= 1'b0;
            r_key_match    <= 4'd0;
            r_json_phase   <= JS_SEARCH;
            r_escape       <= 1'b0;
            r_out_count    <= 12'd0;
        end else if (i_step) begin
            r_byte_count   <= n_byte_count;
            r_magic_ok     <= n_magic_ok;
            r_status_phase <= n_status_phase;
            r_status_value <= n_status_value;
            r_digit_count  <= n_digit_count;
            r_blank_match  <= n_blank_match;
            r_in_body      <= n_in_body;
            r_body_seen    <= n_body_seen;
            r_key_match    <= n_key_match;
            r_json_phase   <= n_json_phase;
            r_escape       <= n_escape;
            r_out_count    <= n_out_count;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the HTTP reply parser: directed replies, then random replies.
`timescale 1ns / 100ps

// The testbench feeds whole HTTP replies into the parser, one byte per transfer,
// and keeps its own byte-level model of the parser. It uses the model to predict
// the content characters and the final verdict of every reply. A short table of
// hand-made replies comes first. It covers every verdict, the status limits, the
// framing errors, escapes, a backslash on the last byte, unterminated strings
// and capacity limits at both ends. Random replies follow, in phases that change
// the reply capacity and the idling pattern of both channels. One phase stalls
// the receiver for a long stretch so that the parser backs up and stalls its input.
module testbench;
    import hrjp_pkg::*;

    // Transfers and results.

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       final_res;
        t_verdict   verdict;
    } t_reply_result;

    localparam int NO_VERDICT     = -1;
    localparam int NO_EXTRA       = -1;
    localparam int PHASE_COUNT    = 7;
    localparam int PRESSURE_PHASE = 5;
    localparam int RANDOM_CAP     = -1;
    localparam int PHASE_BYTES    = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [7:0] MAGIC_TEXT [4]  = '{"H", "T", "T", "P"};
    localparam logic [7:0] BLANK_TEXT [4]  = '{CH_CR, CH_LF, CH_CR, CH_LF};
    localparam logic [7:0] CONTENT_KEY [16] = '{CH_QUOTE, "c", "o", "n", "t", "e", "n", "t",
        CH_QUOTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    // Clock, reset and the parser's ports. All inputs start at known values.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_has_char;
    logic [7:0]  o_out_char;
    logic        o_final_res;
    logic [1:0]  o_verdict;
    logic        i_cfg_we    = 1'b0;
    logic [12:0] i_cfg_wdata = CAP_RESET;

    always #2 i_clk = ~i_clk;

    http_reply_json_content_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_has_char  (o_has_char),
        .o_out_char  (o_out_char),
        .o_final_res (o_final_res),
        .o_verdict   (o_verdict),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Model state of the parser. It mirrors what the parser must remember while
    // it walks through one reply, plus the capacity register.
    logic [12:0]   capacity = CAP_RESET;
    logic [3:0]    seen_len;
    logic          magic_good;
    t_status_phase st_phase;
    logic [9:0]    st_value;
    logic [2:0]    st_digits;
    logic [1:0]    crlf_pos;
    logic          body_on;
    logic          body_any;
    logic [3:0]    key_pos;
    t_json_phase   js_phase;
    logic          esc_wait;
    logic [11:0]   chars_out;

    t_reply_result pending_results [$];
    t_reply_result head_result;
    logic [7:0]    reply_bytes [$];
    int            error_count = 0;

    // Idling controls. The receiver settings are written with nonblocking
    // assignments so the receiver process sees them at a well-defined edge.
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_off_requests = 0;
    int hold_off_served   = 0;
    int hold_left         = 0;

    // Directed table: reply text, capacity, verdict typed in (or left to the
    // model), and an optional trailing byte for values a string cannot carry.
    string row_text [$];
    int    row_cap [$];
    int    row_verdict [$];
    int    row_extra [$];

    string cr      = "\015";
    string crlf    = "\015\012";
    string ok_head;

    int phase_caps [PHASE_COUNT]  = '{3, 4096, 8191, 0, RANDOM_CAP, 4096, 512};
    int phase_modes [PHASE_COUNT] = '{1, 2, 3, 0, 1, 0, 2};

    task automatic clear_reply_state();
        seen_len   = 4'd0;
        magic_good = 1'b1;
        st_phase   = ST_SEEK_SPACE;
        st_value   = 10'd0;
        st_digits  = 3'd0;
        crlf_pos   = 2'd0;
        body_on    = 1'b0;
        body_any   = 1'b0;
        key_pos    = 4'd0;
        js_phase   = JS_SEARCH;
        esc_wait   = 1'b0;
        chars_out  = 12'd0;
    endtask

    // Advances the model by one byte. Returns whether the byte yields a result.
    task automatic predict_reply_byte(input logic [7:0] b, input logic last,
                                      output logic yields, output t_reply_result res);
        logic        take;
        logic [12:0] cap;
        logic        http_good;
        take = 1'b0;
        res  = '0;
        // Capacity zero behaves as one; anything above the maximum is clamped.
        cap = (capacity == 13'd0) ? 13'd1 : ((capacity > CAP_MAX) ? CAP_MAX : capacity);

        // Length and the HTTP magic at the very start.
        if (seen_len < 4'd4 && b != MAGIC_TEXT[seen_len[1:0]]) magic_good = 1'b0;
        if (seen_len < MIN_LEN) seen_len = seen_len + 4'd1;

        // Status line: the first space, then a run of digits. Only the first
        // three digits go into the value, but the count runs on to four.
        case (st_phase)
            ST_SEEK_SPACE: begin
                if (b == CH_SPACE) st_phase = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (b >= CH_0 && b <= CH_9) begin
                    if (st_digits < DIGITS_WANT) st_value = st_value * 10'd10 + 10'(b - CH_0);
                    if (st_digits < DIGITS_SAT) st_digits = st_digits + 3'd1;
                end else begin
                    st_phase = ST_DONE;
                end
            end
            default: ;
        endcase

        if (body_on) begin
            body_any = 1'b1;
            case (js_phase)
                JS_SEARCH: begin
                    if (b == CONTENT_KEY[key_pos]) begin
                        if (key_pos == KEY_LAST) begin
                            key_pos  = 4'd0;
                            js_phase = JS_SKIP;
                        end else begin
                            key_pos = key_pos + 4'd1;
                        end
                    end else begin
                        // A stray quote can itself open the key.
                        key_pos = (b == CH_QUOTE) ? 4'd1 : 4'd0;
                    end
                end
                JS_SKIP: begin
                    if (b == CH_QUOTE) js_phase = JS_STRING;
                    else if (b != CH_SPACE && b != CH_TAB && b != CH_COLON) js_phase = JS_FAILED;
                end
                JS_STRING: begin
                    if (esc_wait) begin
                        esc_wait = 1'b0;
                        take     = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        js_phase = JS_STOPPED;
                    end else if (b == CH_BSLASH && !last) begin
                        esc_wait = 1'b1;
                    end else begin
                        // This includes a backslash on the last byte, which goes out as is.
                        take = 1'b1;
                    end
                    if (take) begin
                        if ({1'b0, chars_out} + 13'd1 >= cap) begin
                            js_phase = JS_STOPPED;
                        end else begin
                            res.has_char = 1'b1;
                            res.out_char = b;
                            chars_out    = chars_out + 12'd1;
                        end
                    end
                end
                default: ;
            endcase
        end else begin
            // Header: look for CR LF CR LF; a CR that breaks the match restarts it.
            if (b == BLANK_TEXT[crlf_pos]) begin
                if (crlf_pos == 2'd3) begin
                    body_on  = 1'b1;
                    crlf_pos = 2'd0;
                end else begin
                    crlf_pos = crlf_pos + 2'd1;
                end
            end else begin
                crlf_pos = (b == CH_CR) ? 2'd1 : 2'd0;
            end
        end

        yields = res.has_char;
        if (last) begin
            http_good = seen_len >= MIN_LEN && magic_good && st_phase != ST_SEEK_SPACE &&
                        st_digits == DIGITS_WANT && st_value >= STATUS_LO && st_value < STATUS_HI;
            res.final_res = 1'b1;
            if (!http_good) res.verdict = VERDICT_HTTP_FAIL;
            else if (!body_any) res.verdict = VERDICT_PARSE_FAIL;
            else if ((js_phase == JS_STRING || js_phase == JS_STOPPED) && chars_out != 12'd0)
                res.verdict = VERDICT_OK;
            else res.verdict = VERDICT_PARSE_FAIL;
            yields = 1'b1;
            clear_reply_state();
        end
    endtask

    // Offers one byte and waits for its transfer. On return the byte has just
    // been taken and valid is still high; the next call either replaces the
    // payload in the same step or lowers valid for a gap.
    task automatic push_byte(input logic [7:0] b, input logic last, input int typed_verdict);
        int            gap;
        logic          yields;
        t_reply_result res;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_byte_in   <= b;
        i_last_byte <= last;
        // The result cannot appear before the byte is taken, so the
        // expectation is queued right away.
        predict_reply_byte(b, last, yields, res);
        if (yields) begin
            if (last && typed_verdict != NO_VERDICT) res.verdict = t_verdict'(typed_verdict);
            pending_results.push_back(res);
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_reply(input int typed_verdict);
        for (int i = 0; i < reply_bytes.size(); i++)
            push_byte(reply_bytes[i], i == reply_bytes.size() - 1, typed_verdict);
    endtask

    // Stops offering bytes and waits until every expected result has arrived.
    // Every reply ends in a result, so the parser is idle shortly after that.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        capacity = value;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin send_idle_pct = 63; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct <= 63; end
            3:       begin send_idle_pct = 12; recv_stall_pct <= 12; end
            default: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        endcase
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
    endtask

    task automatic add_row(input string text, input int cap, input int verdict, input int extra);
        row_text.push_back(text);
        row_cap.push_back(cap);
        row_verdict.push_back(verdict);
        row_extra.push_back(extra);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(32, 126));
    endfunction

    // Builds one random reply. Most are well formed with random status, headers,
    // separators and content; the rest are pure noise or cut off at a random byte.
    task automatic build_random_reply();
        int kind;
        int n;
        int v;
        int r;
        reply_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            n = $urandom_range(1, 30);
            repeat (n) reply_bytes.push_back(any_byte());
            return;
        end
        add_text("HTTP/1.1 ");
        if ($urandom_range(99) < 5) reply_bytes[$urandom_range(3)] = any_byte();
        r = $urandom_range(99);
        if (r < 80) v = 200 + $urandom_range(99);
        else if (r < 88) v = $urandom_range(100, 999);
        else if (r < 94) v = $urandom_range(10, 99);
        else v = $urandom_range(1000, 9999);
        add_text($sformatf("%0d OK", v));
        add_text(crlf);
        n = $urandom_range(2);
        repeat (n) begin
            case ($urandom_range(2))
                0:       add_text({"X-Id: 7", crlf});
                1:       add_text({"A:", cr, "b", crlf});
                default: add_text({"B:", cr, crlf});
            endcase
        end
        add_text(crlf);
        add_text("{");
        n = $urandom_range(3);
        repeat (n) begin
            case ($urandom_range(2))
                0:       add_text("\"conte");
                1:       reply_bytes.push_back(text_byte());
                default: add_text("\"\"");
            endcase
        end
        if ($urandom_range(99) < 92) add_text("\"content\"");
        else add_text("\"Content\"");
        n = $urandom_range(3);
        repeat (n) begin
            case ($urandom_range(2))
                0:       reply_bytes.push_back(CH_SPACE);
                1:       reply_bytes.push_back(CH_TAB);
                default: reply_bytes.push_back(CH_COLON);
            endcase
        end
        if ($urandom_range(99) < 5) reply_bytes.push_back(any_byte());
        reply_bytes.push_back(CH_QUOTE);
        n = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(30, 60);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 10) begin
                reply_bytes.push_back(CH_BSLASH);
                reply_bytes.push_back(any_byte());
            end else if (r < 20) begin
                reply_bytes.push_back(any_byte());
            end else begin
                reply_bytes.push_back(text_byte());
            end
        end
        if ($urandom_range(99) < 85) reply_bytes.push_back(CH_QUOTE);
        add_text("}");
        if (kind < 16) begin
            n = $urandom_range(1, reply_bytes.size());
            while (reply_bytes.size() > n) reply_bytes.delete(reply_bytes.size() - 1);
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endtask

    // Receiver: checks every result transfer against the oldest expectation,
    // then decides ready for the next edge. A long hold-off, once requested,
    // is counted down here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display({"%0t: unexpected result, expected none, ",
                          "got has_char %0d char %0h final %0d verdict %0d"},
                         $time, o_has_char, o_out_char, o_final_res, o_verdict);
            end else begin
                head_result = pending_results.pop_front();
                check_field("has_char", head_result.has_char, o_has_char);
                check_field("out_char", head_result.out_char, o_out_char);
                check_field("final_res", head_result.final_res, o_final_res);
                check_field("verdict", head_result.verdict, o_verdict);
            end
        end
        if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_left       = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and the end of the run.
    initial begin
        int sent;
        int cap;
        clear_reply_state();
        ok_head = {"HTTP/1.1 200 OK", crlf, crlf};

        // Each row ends in exactly one final result. The capacity of the first
        // rows is the reset value, so nothing is written before them.
        add_row({ok_head, "{\"content\":\"hi\"}"}, 512, VERDICT_OK, NO_EXTRA);
        // A failed status still lets the characters out; the consumer drops them.
        add_row({"HTTP/1.1 404 NF", crlf, crlf, "{\"content\":\"x\"}"}, 512,
                VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row("HTTP/1.1 20", 512, VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTX/1.1 200 OK", crlf, crlf, "{}"}, 512, VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1-200-OK", crlf, crlf, "{}"}, 512, VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1 2000 OK", crlf, crlf, "{\"content\":\"a\"}"}, 512,
                VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1 20 OK", crlf, crlf, "{\"content\":\"a\"}"}, 512,
                VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1 199 X", crlf, crlf, "{\"content\":\"a\"}"}, 512,
                VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1 300 X", crlf, crlf, "{\"content\":\"a\"}"}, 512,
                VERDICT_HTTP_FAIL, NO_EXTRA);
        add_row({"HTTP/1.1 299 X", crlf, crlf, "{\"content\":\"z\"}"}, 512, VERDICT_OK, NO_EXTRA);
        add_row({"HTTP/1.1 200 OK", crlf, "A: b", crlf}, 512, VERDICT_PARSE_FAIL, NO_EXTRA);
        // The reply ends on the blank line itself: no body byte follows.
        add_row(ok_head, 512, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"contend\":\"a\"}"}, 512, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"content\" =\"a\"}"}, 512, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"\"}"}, 512, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"a\\\"b\\\\c\"}"}, 512, NO_VERDICT, NO_EXTRA);
        add_row({ok_head, "{\"\"content\": \t:\"q\"}"}, 512, NO_VERDICT, NO_EXTRA);
        // Backslash as the very last byte, and a string that never closes.
        add_row({ok_head, "{\"content\":\"ab\\"}, 512, VERDICT_OK, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"abc"}, 512, VERDICT_OK, NO_EXTRA);
        // Capacity limits: extraction stops quietly once the buffer is full.
        add_row({ok_head, "{\"content\":\"abcdef\"}"}, 3, VERDICT_OK, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"ab\"}"}, 2, VERDICT_OK, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"abcdef\"}"}, 1, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"content\":\"abcdef\"}"}, 0, VERDICT_PARSE_FAIL, NO_EXTRA);
        add_row({ok_head, "{\"content\":\""}, 8191, VERDICT_OK, 8'hFF);
        add_row({ok_head, "{\"content\":\"x"}, 4096, VERDICT_OK, 8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle_mode(0);
        for (int k = 0; k < row_text.size(); k++) begin
            if (13'(row_cap[k]) != capacity) write_capacity(13'(row_cap[k]));
            reply_bytes.delete();
            add_text(row_text[k]);
            if (row_extra[k] != NO_EXTRA) reply_bytes.push_back(8'(row_extra[k]));
            send_reply(row_verdict[k]);
        end

        // Random phases, each with its own capacity and idling pattern.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            cap = phase_caps[p];
            if (cap == RANDOM_CAP)
                cap = ($urandom_range(99) < 50) ? $urandom_range(1, 12) : $urandom_range(8191);
            write_capacity(13'(cap));
            set_idle_mode(phase_modes[p]);
            if (p == PRESSURE_PHASE) begin
                // The receiver holds off while a long string streams in, so
                // both internal registers fill and the input stalls.
                hold_off_requests <= hold_off_requests + 1;
                reply_bytes.delete();
                add_text({ok_head, "{\"content\":\""});
                repeat (80) reply_bytes.push_back(8'($urandom_range(97, 122)));
                add_text("\"}");
                send_reply(NO_VERDICT);
            end else begin
                sent = 0;
                while (sent < PHASE_BYTES) begin
                    build_random_reply();
                    sent += reply_bytes.size();
                    send_reply(NO_VERDICT);
                end
            end
        end

        wait_drained();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
